>>> hw/rtl/mrse_pkg.sv
// ----------------------------------------------------------------------------
// mrse_pkg
// Shared types, codes and helpers for the multichannel random slew engine.
// ----------------------------------------------------------------------------
package mrse_pkg;

    localparam logic [16:0] ONE_FX = 17'h10000;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_RAND    = 2'd1,
        CMD_CAPTURE = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_code_t;

    localparam logic [1:0] REG_RAND_DEPTH = 2'd0;
    localparam logic [1:0] REG_SLEW_STEPS = 2'd1;
    localparam logic [1:0] REG_FREEZE     = 2'd2;
    localparam logic [1:0] REG_FORCE      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_RMUL,
        S_RFIN,
        S_BM1,
        S_BM2,
        S_BSUM,
        S_DIV,
        S_BDONE,
        S_WB
    } state_t;

    typedef struct packed {
        logic idle;
        logic eval;
        logic rmul;
        logic rfin;
        logic bm1;
        logic bm2;
        logic bsum;
        logic dstep;
        logic bdone;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic is_rand;
        logic need_blend;
        logic more_blend;
        logic div_last;
        logic out_free;
    } dp_sts_t;

    function automatic logic [16:0] sat_one(input logic [16:0] v);
        return (v > ONE_FX) ? ONE_FX : v;
    endfunction

endpackage

>>> hw/rtl/mrse_if.sv
// ----------------------------------------------------------------------------
// mrse_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface mrse_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [5:0]  channel;
    logic [16:0] live_value;
    logic [16:0] random_offset;
    logic        pivot_on;
    logic        rand_enabled;

    modport source (
        output valid, cmd, channel, live_value, random_offset, pivot_on, rand_enabled,
        input  ready
    );
    modport sink (
        input  valid, cmd, channel, live_value, random_offset, pivot_on, rand_enabled,
        output ready
    );
endinterface

interface mrse_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  out_channel;
    logic [16:0] out_value;
    logic        write_strobe;
    logic        is_slewing;

    modport source (
        output valid, out_channel, out_value, write_strobe, is_slewing,
        input  ready
    );
    modport sink (
        input  valid, out_channel, out_value, write_strobe, is_slewing,
        output ready
    );
endinterface

>>> hw/rtl/mrse_ram.sv
// ----------------------------------------------------------------------------
// mrse_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module mrse_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/mrse_ctrl.sv
// ----------------------------------------------------------------------------
// mrse_ctrl
// Sequencer: read, evaluate, multiply/divide steps, commit.
// ----------------------------------------------------------------------------
module mrse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  mrse_pkg::dp_sts_t sts,
    output mrse_pkg::dp_cmd_t cmd
);

    mrse_pkg::state_t state_reg;
    mrse_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrse_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrse_pkg::S_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = mrse_pkg::S_READ;
                end
            end
            mrse_pkg::S_READ:  state_next = mrse_pkg::S_EVAL;
            mrse_pkg::S_EVAL:
            begin
                if (sts.is_rand)
                begin
                    state_next = mrse_pkg::S_RMUL;
                end
                else if (sts.need_blend)
                begin
                    state_next = mrse_pkg::S_BM1;
                end
                else
                begin
                    state_next = mrse_pkg::S_WB;
                end
            end
            mrse_pkg::S_RMUL:  state_next = mrse_pkg::S_RFIN;
            mrse_pkg::S_RFIN:  state_next = mrse_pkg::S_WB;
            mrse_pkg::S_BM1:   state_next = mrse_pkg::S_BM2;
            mrse_pkg::S_BM2:   state_next = mrse_pkg::S_BSUM;
            mrse_pkg::S_BSUM:  state_next = mrse_pkg::S_DIV;
            mrse_pkg::S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = mrse_pkg::S_BDONE;
                end
            end
            mrse_pkg::S_BDONE:
            begin
                state_next = sts.more_blend ? mrse_pkg::S_BM1 : mrse_pkg::S_WB;
            end
            mrse_pkg::S_WB:
            begin
                if (sts.out_free)
                begin
                    state_next = mrse_pkg::S_IDLE;
                end
            end
            default: state_next = mrse_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.idle   = (state_reg == mrse_pkg::S_IDLE);
        cmd.eval   = (state_reg == mrse_pkg::S_EVAL);
        cmd.rmul   = (state_reg == mrse_pkg::S_RMUL);
        cmd.rfin   = (state_reg == mrse_pkg::S_RFIN);
        cmd.bm1    = (state_reg == mrse_pkg::S_BM1);
        cmd.bm2    = (state_reg == mrse_pkg::S_BM2);
        cmd.bsum   = (state_reg == mrse_pkg::S_BSUM);
        cmd.dstep  = (state_reg == mrse_pkg::S_DIV);
        cmd.bdone  = (state_reg == mrse_pkg::S_BDONE);
        cmd.commit = (state_reg == mrse_pkg::S_WB) && sts.out_free;
    end

endmodule

>>> hw/rtl/mrse_dp.sv
// ----------------------------------------------------------------------------
// mrse_dp
// Channel stores, config registers, shared multiplier, restoring divider
// and result register.
// ----------------------------------------------------------------------------
module mrse_dp #(
    parameter int CHANNELS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    mrse_in_if.sink           in_ch,
    mrse_out_if.source        out_ch,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [16:0]       cfg_data,
    input  mrse_pkg::dp_cmd_t cmd,
    output mrse_pkg::dp_sts_t sts
);

    localparam int DEPTH = (CHANNELS < 64) ? CHANNELS : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // config
    logic [16:0] rand_depth_reg;
    logic [15:0] slew_steps_reg;
    logic        freeze_reg;
    logic        force_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rand_depth_reg <= 17'd32768;
            slew_steps_reg <= '0;
            freeze_reg     <= 1'b0;
            force_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mrse_pkg::REG_RAND_DEPTH: rand_depth_reg <= cfg_data;
                mrse_pkg::REG_SLEW_STEPS: slew_steps_reg <= cfg_data[15:0];
                mrse_pkg::REG_FREEZE:     freeze_reg     <= cfg_data[0];
                mrse_pkg::REG_FORCE:      force_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured item
    mrse_pkg::cmd_code_t cmd_q;
    logic [5:0]          ch_q;
    logic [16:0]         live_q;
    logic [16:0]         roff_q;
    logic                pivsel_q;
    logic                en_q;

    assign in_ch.ready = cmd.idle;

    always_ff @(posedge clk)
    begin
        if (cmd.idle && in_ch.valid)
        begin
            cmd_q    <= mrse_pkg::cmd_code_t'(in_ch.cmd);
            ch_q     <= in_ch.channel;
            live_q   <= mrse_pkg::sat_one(in_ch.live_value);
            roff_q   <= in_ch.random_offset;
            pivsel_q <= in_ch.pivot_on;
            en_q     <= in_ch.rand_enabled;
        end
    end

    logic          in_range;
    logic [AW-1:0] addr;
    logic          is_init;
    logic          is_rand;
    logic          is_cap;
    logic          tick_live;

    assign in_range  = ({5'd0, ch_q} < 11'(CHANNELS));
    assign addr      = ch_q[AW-1:0];
    assign is_init   = in_range && (cmd_q == mrse_pkg::CMD_INIT);
    assign is_rand   = in_range && (cmd_q == mrse_pkg::CMD_RAND);
    assign is_cap    = in_range && (cmd_q == mrse_pkg::CMD_CAPTURE);
    assign tick_live = in_range && (cmd_q == mrse_pkg::CMD_TICK) && !freeze_reg;

    // work registers
    logic [16:0] cur_w;
    logic [16:0] prior_w;
    logic [16:0] target_w;
    logic [15:0] sc_w;
    logic        slew_w;
    logic        rt_reg;
    logic [16:0] value_w;
    logic [16:0] base_w;
    logic [16:0] ba_reg;
    logic [16:0] bb_reg;
    logic [15:0] bc_reg;

    // stores
    logic [16:0] cur_rd;
    logic [16:0] prior_rd;
    logic [16:0] target_rd;
    logic [15:0] step_rd;
    logic [16:0] pivot_rd;
    logic        cur_we;
    logic        tick_we;
    logic        pivot_we;
    logic [16:0] cur_wd;

    assign cur_we   = cmd.commit && (is_init || is_rand);
    assign tick_we  = cmd.commit && tick_live;
    assign pivot_we = cmd.commit && is_cap;
    assign cur_wd   = is_init ? live_q : value_w;

    mrse_ram #(.WIDTH(17), .DEPTH(DEPTH), .AW(AW)) u_cur_ram (
        .clk(clk), .we(cur_we), .waddr(addr), .wdata(cur_wd), .raddr(addr), .rdata(cur_rd)
    );
    mrse_ram #(.WIDTH(17), .DEPTH(DEPTH), .AW(AW)) u_prior_ram (
        .clk(clk), .we(tick_we), .waddr(addr), .wdata(prior_w), .raddr(addr),
        .rdata(prior_rd)
    );
    mrse_ram #(.WIDTH(17), .DEPTH(DEPTH), .AW(AW)) u_target_ram (
        .clk(clk), .we(tick_we), .waddr(addr), .wdata(target_w), .raddr(addr),
        .rdata(target_rd)
    );
    mrse_ram #(.WIDTH(16), .DEPTH(DEPTH), .AW(AW)) u_step_ram (
        .clk(clk), .we(tick_we), .waddr(addr), .wdata(sc_w), .raddr(addr), .rdata(step_rd)
    );
    mrse_ram #(.WIDTH(17), .DEPTH(DEPTH), .AW(AW)) u_pivot_ram (
        .clk(clk), .we(pivot_we), .waddr(addr), .wdata(live_q), .raddr(addr),
        .rdata(pivot_rd)
    );

    // step counter started flags; clear means "not yet started"
    logic [DEPTH-1:0] started_reg;
    logic             started;
    logic             pivot_valid_reg;

    assign started = in_range && started_reg[addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= '0;
            pivot_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (is_init)
            begin
                started_reg[addr] <= 1'b0;
            end
            if (tick_live)
            begin
                started_reg[addr] <= 1'b1;
            end
            if (is_cap)
            begin
                pivot_valid_reg <= 1'b1;
            end
        end
    end

    // tick evaluation
    logic [15:0] s;
    logic [16:0] pr0;
    logic [15:0] sc0;
    logic        ge;
    logic [16:0] pr1;
    logic [16:0] tg1;
    logic [15:0] sc1;
    logic        sl1;
    logic        flip;
    logic [16:0] tg2;
    logic [15:0] sc2;
    logic        do_ramp;
    logic        retg;
    logic [15:0] back;

    assign s       = slew_steps_reg;
    assign pr0     = started ? prior_rd : cur_rd;
    assign sc0     = started ? step_rd : 16'd0;
    assign ge      = (sc0 >= s);
    assign pr1     = ge ? cur_rd : pr0;
    assign tg1     = ge ? cur_rd : target_rd;
    assign sc1     = ge ? 16'd0 : sc0;
    assign sl1     = !ge && (sc0 != 16'd0);
    assign flip    = !sl1 && (cur_rd != pr1);
    assign tg2     = flip ? cur_rd : tg1;
    assign sc2     = flip ? 16'd0 : sc1;
    assign do_ramp = (sl1 || flip) && (s != 16'd0);
    assign retg    = do_ramp && (cur_rd != tg2);
    assign back    = (sc2 != 16'd0) ? (sc2 - 16'd1) : 16'd0;

    // shared multiplier
    logic [16:0]        depth;
    logic [16:0]        s_minus_c;
    logic signed [17:0] ma;
    logic signed [17:0] mb;
    logic signed [35:0] prod_reg;
    logic [33:0]        acc_reg;

    assign depth     = mrse_pkg::sat_one(rand_depth_reg);
    assign s_minus_c = {1'b0, s} - {1'b0, bc_reg};

    always_comb
    begin
        ma = '0;
        mb = '0;
        if (cmd.rmul)
        begin
            ma = {roff_q[16], roff_q};
            mb = {1'b0, depth};
        end
        else if (cmd.bm1)
        begin
            ma = {1'b0, s_minus_c};
            mb = {1'b0, ba_reg};
        end
        else
        begin
            ma = {2'b00, bc_reg};
            mb = {1'b0, bb_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rmul || cmd.bm1 || cmd.bm2)
        begin
            prod_reg <= ma * mb;
        end
        if (cmd.bm2)
        begin
            acc_reg <= prod_reg[33:0];
        end
    end

    // randomize finish
    logic signed [35:0] biased;
    logic signed [19:0] off20;
    logic signed [19:0] sum20;
    logic [16:0]        rand_val;

    assign biased = prod_reg + 36'sd32768;
    assign off20  = biased[35:16];
    assign sum20  = $signed({3'b000, base_w}) + off20;

    always_comb
    begin
        if (sum20 < 20'sd0)
        begin
            rand_val = '0;
        end
        else if (sum20 > 20'sd65536)
        begin
            rand_val = mrse_pkg::ONE_FX;
        end
        else
        begin
            rand_val = sum20[16:0];
        end
    end

    // restoring divider, quotient known to fit in 17 bits
    logic [33:0] num;
    logic [16:0] rem_reg;
    logic [16:0] dq_reg;
    logic [4:0]  div_cnt;
    logic [17:0] trial;
    logic        trial_ge;

    assign num      = acc_reg + prod_reg[33:0] + {19'd0, s[15:1]};
    assign trial    = {rem_reg, dq_reg[16]};
    assign trial_ge = (trial >= {2'b00, s});

    always_ff @(posedge clk)
    begin
        if (cmd.bsum)
        begin
            rem_reg <= num[33:17];
            dq_reg  <= num[16:0];
            div_cnt <= '0;
        end
        else if (cmd.dstep)
        begin
            rem_reg <= trial_ge ? 17'(trial - {2'b00, s}) : trial[16:0];
            dq_reg  <= {dq_reg[15:0], trial_ge};
            div_cnt <= div_cnt + 5'd1;
        end
    end

    // work register updates
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            cur_w    <= cur_rd;
            prior_w  <= pr1;
            target_w <= tg2;
            sc_w     <= sc2;
            slew_w   <= tick_live && do_ramp;
            rt_reg   <= tick_live && retg;
            ba_reg   <= pr1;
            bb_reg   <= retg ? tg2 : cur_rd;
            bc_reg   <= retg ? back : sc2;
            base_w   <= (pivsel_q && pivot_valid_reg) ? mrse_pkg::sat_one(pivot_rd) : live_q;
            if (!in_range)
            begin
                value_w <= '0;
            end
            else if ((cmd_q == mrse_pkg::CMD_INIT) || (cmd_q == mrse_pkg::CMD_CAPTURE))
            begin
                value_w <= live_q;
            end
            else
            begin
                value_w <= cur_rd;
            end
        end
        else if (cmd.rfin)
        begin
            value_w <= rand_val;
        end
        else if (cmd.bdone)
        begin
            if (rt_reg)
            begin
                prior_w  <= mrse_pkg::sat_one(dq_reg);
                target_w <= cur_w;
                ba_reg   <= mrse_pkg::sat_one(dq_reg);
                bb_reg   <= cur_w;
                bc_reg   <= '0;
                sc_w     <= '0;
                rt_reg   <= 1'b0;
            end
            else
            begin
                value_w <= mrse_pkg::sat_one(dq_reg);
                sc_w    <= sc_w + 16'd1;
            end
        end
    end

    // result register
    logic        out_valid_reg;
    logic [5:0]  out_channel_reg;
    logic [16:0] out_value_reg;
    logic        strobe_reg;
    logic        slewing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_channel_reg <= ch_q;
            out_value_reg   <= value_w;
            strobe_reg      <= (is_rand && en_q && (s == 16'd0))
                            || (slew_w && (en_q || force_reg));
            slewing_reg     <= slew_w;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_channel  = out_channel_reg;
    assign out_ch.out_value    = out_value_reg;
    assign out_ch.write_strobe = strobe_reg;
    assign out_ch.is_slewing   = slewing_reg;

    always_comb
    begin
        sts            = '0;
        sts.in_valid   = in_ch.valid;
        sts.is_rand    = is_rand;
        sts.need_blend = tick_live && do_ramp;
        sts.more_blend = rt_reg;
        sts.div_last   = (div_cnt == 5'd16);
        sts.out_free   = !out_valid_reg || out_ch.ready;
    end

`ifndef NO_ASSERTIONS
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ch.ready))
        else $error("commit while result register occupied");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bdone |-> ($past(cmd.dstep) && ($past(div_cnt) == 5'd16)))
        else $error("divide ended early");

    a_pivot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(pivot_valid_reg) |-> pivot_valid_reg)
        else $error("pivot valid dropped");
`endif

endmodule

>>> hw/rtl/multichannel_random_slew_engine_top.sv
// Sequence: init, capture, frozen tick, plain tick go read, evaluate, write back;
// randomize adds a multiply and finish; a ramp tick adds a blend, two when the target moves mid-ramp.
// Each blend is a multiply pair plus a 17-step restoring divide by slew_steps.
// One item in flight: an item occupies the engine until its result is committed, which waits out output stalls.
// Reset clears config, state machine, step-started flags and pivot valid;
// value stores are undefined until written.
// ----------------------------------------------------------------------------
// multichannel_random_slew_engine_top
// Per-channel randomizer with linear slew ramps.
// ----------------------------------------------------------------------------
module multichannel_random_slew_engine_top #(
    parameter int CHANNELS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    mrse_in_if.sink     in_ch,
    mrse_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    mrse_pkg::dp_cmd_t cmd;
    mrse_pkg::dp_sts_t sts;

    mrse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    mrse_dp #(.CHANNELS(CHANNELS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> verif/tb_multichannel_random_slew_engine_top.sv
// ----------------------------------------------------------------------------
// tb_multichannel_random_slew_engine_top
// Self-checking bench: a directed table, then random command streams checked
// against an in-bench predictor of per-channel randomize and slew behavior.
// ----------------------------------------------------------------------------
module tb_multichannel_random_slew_engine_top;

    typedef struct packed {
        logic [5:0]  ch;
        logic [16:0] value;
        logic        strobe;
        logic        slewing;
    } slew_result_t;

    typedef struct {
        mrse_pkg::cmd_code_t cmd;
        logic [5:0]          ch;
        logic [16:0]         live;
        logic [16:0]         offs;
        logic                piv;
        logic                en;
        logic                has_exp;
        logic [16:0]         exp_value;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    mrse_in_if  in_ch ();
    mrse_out_if out_ch ();

    multichannel_random_slew_engine_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [16:0] depth_q;
    logic [15:0] steps_q;
    logic        freeze_q;
    logic        force_q;
    logic [16:0] cur_q [64];
    logic [16:0] prior_q [64];
    logic [16:0] tgt_q [64];
    int          cnt_q [64];
    logic [16:0] pivot_q [64];
    logic        pivot_ok;
    logic        inited [64];
    logic        captured [64];

    slew_result_t expected_q [$];
    logic [16:0]  typed_q [$];
    logic         typed_has_q [$];
    int           errors = 0;
    int           pending = 0;
    logic         idle_on = 1'b1;

    function automatic logic [16:0] clamp_one(longint v);
        if (v < 0) return 17'd0;
        if (v > 65536) return 17'd65536;
        return v[16:0];
    endfunction

    function automatic logic [16:0] ramp_mix(longint s, longint c, longint a, longint b);
        longint num;
        num = (s - c) * a + c * b;
        return clamp_one((num + s / 2) / s);
    endfunction

    function automatic logic [16:0] apply_offset(logic [16:0] base, logic [16:0] offs);
        longint r, d, prod, off;
        r = longint'($signed(offs));
        d = (depth_q > 17'd65536) ? 65536 : longint'(depth_q);
        prod = r * d + 32768;
        off = ((prod + (longint'(1) << 40)) >>> 16) - (longint'(1) << 24);
        return clamp_one(longint'(base) + off);
    endfunction

    function automatic slew_result_t predict_slew(mrse_pkg::cmd_code_t cmd, logic [5:0] ch,
                                                  logic [16:0] live_in, logic [16:0] offs,
                                                  logic piv, logic en);
        slew_result_t res;
        logic [16:0] live, base, cur;
        longint s;
        int done, back;
        logic slewing;
        live = mrse_pkg::sat_one(live_in);
        res = '0;
        res.ch = ch;
        case (cmd)
            mrse_pkg::CMD_INIT:
            begin
                cur_q[ch] = live;
                cnt_q[ch] = -1;
                inited[ch] = 1'b1;
                res.value = live;
            end
            mrse_pkg::CMD_RAND:
            begin
                base = (piv && pivot_ok) ? pivot_q[ch] : live;
                cur_q[ch] = apply_offset(mrse_pkg::sat_one(base), offs);
                inited[ch] = 1'b1;
                res.value = cur_q[ch];
                res.strobe = (steps_q == 0) && en;
            end
            mrse_pkg::CMD_CAPTURE:
            begin
                pivot_q[ch] = live;
                pivot_ok = 1'b1;
                captured[ch] = 1'b1;
                res.value = live;
            end
            default:
            begin
                if (freeze_q)
                    res.value = cur_q[ch];
                else
                begin
                    s = steps_q;
                    cur = cur_q[ch];
                    if (cnt_q[ch] < 0)
                    begin
                        prior_q[ch] = cur;
                        cnt_q[ch] = 0;
                    end
                    slewing = cnt_q[ch] != 0;
                    res.value = cur;
                    if (cnt_q[ch] >= s)
                    begin
                        cnt_q[ch] = 0;
                        prior_q[ch] = cur;
                        tgt_q[ch] = cur;
                        slewing = 1'b0;
                    end
                    if (!slewing && cur != prior_q[ch])
                    begin
                        tgt_q[ch] = cur;
                        cnt_q[ch] = 0;
                        slewing = 1'b1;
                    end
                    if (slewing && s != 0)
                    begin
                        if (cur != tgt_q[ch])
                        begin
                            done = cnt_q[ch];
                            back = done > 0 ? done - 1 : 0;
                            prior_q[ch] = ramp_mix(s, back, prior_q[ch], tgt_q[ch]);
                            tgt_q[ch] = cur;
                            cnt_q[ch] = 0;
                        end
                        res.value = ramp_mix(s, cnt_q[ch], prior_q[ch], cur);
                        cnt_q[ch]++;
                    end
                    else
                        slewing = 1'b0;
                    res.slewing = slewing;
                    res.strobe = slewing && (en || force_q);
                end
            end
        endcase
        return res;
    endfunction

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(negedge clk);
    endtask

    task automatic send_cmd(mrse_pkg::cmd_code_t cmd, logic [5:0] ch, logic [16:0] live,
                            logic [16:0] offs, logic piv, logic en,
                            logic has_exp, logic [16:0] exp_value);
        expected_q = {expected_q, predict_slew(cmd, ch, live, offs, piv, en)};
        typed_q = {typed_q, exp_value};
        typed_has_q = {typed_has_q, has_exp};
        pending++;
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.channel <= ch;
        in_ch.live_value <= live;
        in_ch.random_offset <= offs;
        in_ch.pivot_on <= piv;
        in_ch.rand_enabled <= en;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        @(negedge clk);
        idle_gap();
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mrse_pkg::REG_RAND_DEPTH: depth_q = val;
            mrse_pkg::REG_SLEW_STEPS: steps_q = val[15:0];
            mrse_pkg::REG_FREEZE:     freeze_q = val[0];
            default:                  force_q = val[0];
        endcase
    endtask

    // result checker
    always @(posedge clk)
    begin
        slew_result_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected transfer on out_ch");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (typed_has_q.pop_front() && typed_q[0] != e.value)
                begin
                    $error("table out_value expected %0d predicted %0d", typed_q[0], e.value);
                    errors++;
                end
                void'(typed_q.pop_front());
                if (out_ch.out_channel !== e.ch)
                begin
                    $error("out_channel expected %0d actual %0d", e.ch, out_ch.out_channel);
                    errors++;
                end
                if (out_ch.out_value !== e.value)
                begin
                    $error("out_value expected %0d actual %0d", e.value, out_ch.out_value);
                    errors++;
                end
                if (out_ch.write_strobe !== e.strobe)
                begin
                    $error("write_strobe expected %0d actual %0d", e.strobe,
                           out_ch.write_strobe);
                    errors++;
                end
                if (out_ch.is_slewing !== e.slewing)
                begin
                    $error("is_slewing expected %0d actual %0d", e.slewing,
                           out_ch.is_slewing);
                    errors++;
                end
                pending--;
            end
        end
    end

    // receiver stalls
    initial
    begin
        out_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #10000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic random_item(logic allow_pivot);
        mrse_pkg::cmd_code_t cmd;
        logic [5:0] ch;
        logic [16:0] live, offs;
        logic piv;
        int k;
        ch = 6'($urandom_range(0, 7));
        if ($urandom_range(0, 4) == 0) ch = 6'($urandom_range(0, 63));
        k = $urandom_range(0, 9);
        cmd = k < 1 ? mrse_pkg::CMD_INIT : k < 4 ? mrse_pkg::CMD_RAND
            : k < 5 ? mrse_pkg::CMD_CAPTURE : mrse_pkg::CMD_TICK;
        if (!inited[ch] && cmd == mrse_pkg::CMD_TICK) cmd = mrse_pkg::CMD_INIT;
        live = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        offs = ($urandom_range(0, 5) == 0) ? 17'($urandom)
                                            : 17'($signed($urandom_range(0, 65536)) - 32768);
        piv = allow_pivot && $urandom_range(0, 1);
        if (piv && pivot_ok && !captured[ch]) piv = 1'b0;
        send_cmd(cmd, ch, live, offs, piv, 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    initial
    begin
        stim_row_t rows [16];
        int n;
        int steps_opts [4];
        steps_opts = '{1, 3, 7, 65535};
        for (int i = 0; i < 64; i++)
        begin
            cnt_q[i] = -1;
            inited[i] = 1'b0;
            captured[i] = 1'b0;
            cur_q[i] = '0;
            prior_q[i] = '0;
            tgt_q[i] = '0;
            pivot_q[i] = '0;
        end
        depth_q = 17'd32768;
        steps_q = '0;
        freeze_q = 1'b0;
        force_q = 1'b0;
        pivot_ok = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = mrse_pkg::CMD_INIT;
        in_ch.channel = '0;
        in_ch.live_value = '0;
        in_ch.random_offset = '0;
        in_ch.pivot_on = 1'b0;
        in_ch.rand_enabled = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // cmd, ch, live, offset, pivot, enabled, typed?, expected value
        rows = '{
            '{mrse_pkg::CMD_INIT,    6'd0,  17'd0,     17'd0,     1'b0, 1'b0, 1'b1, 17'd0},
            '{mrse_pkg::CMD_INIT,    6'd63, 17'd65536, 17'd0,     1'b0, 1'b0, 1'b1, 17'd65536},
            '{mrse_pkg::CMD_INIT,    6'd1,  17'h1FFFF, 17'd0,     1'b0, 1'b0, 1'b1, 17'd65536},
            '{mrse_pkg::CMD_TICK,    6'd0,  17'd0,     17'd0,     1'b0, 1'b1, 1'b1, 17'd0},
            '{mrse_pkg::CMD_RAND,    6'd0,  17'd0,     17'h18000, 1'b0, 1'b1, 1'b1, 17'd0},
            '{mrse_pkg::CMD_RAND,    6'd63, 17'd65536, 17'd32768, 1'b0, 1'b1, 1'b1, 17'd65536},
            '{mrse_pkg::CMD_RAND,    6'd2,  17'd32768, 17'd32768, 1'b0, 1'b1, 1'b1, 17'd49152},
            '{mrse_pkg::CMD_RAND,    6'd3,  17'd32768, 17'h18000, 1'b1, 1'b0, 1'b1, 17'd16384},
            '{mrse_pkg::CMD_RAND,    6'd4,  17'd100,   17'h1FFFF, 1'b0, 1'b1, 1'b0, 17'd0},
            '{mrse_pkg::CMD_RAND,    6'd5,  17'h1FFFF, 17'h10000, 1'b0, 1'b0, 1'b0, 17'd0},
            '{mrse_pkg::CMD_CAPTURE, 6'd2,  17'd40000, 17'd0,     1'b0, 1'b0, 1'b1, 17'd40000},
            '{mrse_pkg::CMD_CAPTURE, 6'd63, 17'h1FFFF, 17'd0,     1'b0, 1'b0, 1'b1, 17'd65536},
            '{mrse_pkg::CMD_RAND,    6'd2,  17'd0,     17'd0,     1'b1, 1'b1, 1'b0, 17'd0},
            '{mrse_pkg::CMD_RAND,    6'd63, 17'd0,     17'd1,     1'b1, 1'b1, 1'b0, 17'd0},
            '{mrse_pkg::CMD_TICK,    6'd2,  17'd0,     17'd0,     1'b0, 1'b1, 1'b0, 17'd0},
            '{mrse_pkg::CMD_TICK,    6'd63, 17'h1FFFF, 17'h1FFFF, 1'b1, 1'b0, 1'b0, 17'd0}
        };
        foreach (rows[i])
            send_cmd(rows[i].cmd, rows[i].ch, rows[i].live, rows[i].offs, rows[i].piv,
                     rows[i].en, rows[i].has_exp, rows[i].exp_value);

        write_reg(mrse_pkg::REG_RAND_DEPTH, 17'd65536);
        write_reg(mrse_pkg::REG_SLEW_STEPS, 17'd4);
        for (int i = 0; i < 8; i++)
            send_cmd(i % 3 == 0 ? mrse_pkg::CMD_RAND : mrse_pkg::CMD_TICK, 6'd2, 17'd30000,
                     17'd20000 - 17'(i * 7000), 1'b0, 1'b1, 1'b0, '0);

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 6)
                0: write_reg(mrse_pkg::REG_SLEW_STEPS, 17'(steps_opts[$urandom_range(0, 2)]));
                1: write_reg(mrse_pkg::REG_RAND_DEPTH, phase < 6 ? 17'd0 : 17'h1FFFF);
                2: write_reg(mrse_pkg::REG_FORCE, 17'(phase < 6));
                3: write_reg(mrse_pkg::REG_FREEZE, 17'd1);
                4: write_reg(mrse_pkg::REG_FREEZE, 17'd0);
                default: write_reg(mrse_pkg::REG_SLEW_STEPS, phase < 6 ? 17'd65535 : 17'd0);
            endcase
            n = (phase == 5 || phase == 11) ? 25 : 130;
            if (phase == 11) idle_on = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                random_item(1'b1);
                if (phase == 6 && i == 50)
                    while (pending != 0) @(negedge clk);
            end
        end
        write_reg(mrse_pkg::REG_RAND_DEPTH, 17'($urandom_range(0, 65536)));
        write_reg(mrse_pkg::REG_SLEW_STEPS, 17'd2);
        for (int i = 0; i < 260; i++)
            random_item(1'b1);

        drain();
        if (errors == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/mrse_pkg.sv
hw/rtl/mrse_if.sv
hw/rtl/mrse_ram.sv
hw/rtl/mrse_ctrl.sv
hw/rtl/mrse_dp.sv
hw/rtl/multichannel_random_slew_engine_top.sv
verif/tb_multichannel_random_slew_engine_top.sv
